FILE: rtl/core/rbsm_pkg.sv
// rbsm_pkg: request and status codes, state and result types for the ring buffer space manager
// no dependencies; imported by rbsm_eval, ring_buffer_space_manager_top, rbsm_checker and the testbench
package rbsm_pkg;

    localparam int unsigned POS_W = 16;

    localparam logic [POS_W-1:0] CAP_RESET = 16'd4096;

    typedef enum logic [1:0] {
        REQ_RESERVE = 2'd0,
        REQ_COMMIT  = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_CONSUME = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_REFUSED   = 2'd2
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] write_pos;
        logic [POS_W-1:0] read_pos;
        logic [POS_W-1:0] fill_count;
        logic             wrapped_flag;
    } ring_state_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] slice_offset;
        logic [POS_W-1:0] slice_length;
        logic             slice_contiguous;
    } result_t;

endpackage

FILE: rtl/core/ring_buffer_space_manager_top.sv
// ring_buffer_space_manager_top: input register, request evaluation, ring state and result register
// depends on rbsm_pkg and rbsm_eval
//
//   channel   | direction | fields
//   s_axis    | in        | tuser[1:0] req_type; tdata[15:0] byte_count
//   m_axis    | out       | tuser[1:0] status; tdata slice_offset, slice_length, slice_contiguous
//   cfg       | in        | cfg_wdata[15:0] region_capacity, written when cfg_we is high and cfg_wdata is nonzero
//
// a request is held in the input register, is evaluated and its result is registered;
// one request per cycle sustained while the result is not stalled
// reset clears positions, fill count and wrap flag and sets the capacity to 4096
// a stalled result holds the result register; the input register still takes one more request
module ring_buffer_space_manager_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] byte_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] slice_offset, [31:16] slice_length,
                                        // [32] slice_contiguous, [39:33] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import rbsm_pkg::*;

    logic              in_valid_reg;
    logic [1:0]        in_req_reg;
    logic [POS_W-1:0]  in_count_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    ring_state_t       state_reg;
    ring_state_t       state_next;
    logic [POS_W-1:0]  cap_reg;
    result_t           eval_res;
    logic              advance;
    logic              in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    rbsm_eval u_eval (
        .capacity   (cap_reg),
        .cur_state  (state_reg),
        .req_type   (req_t'(in_req_reg)),
        .byte_count (in_count_reg),
        .result     (eval_res),
        .next_state (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we && (cfg_wdata != '0))
            begin
                cap_reg   <= cfg_wdata;
                state_reg <= '0;
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg   <= s_axis_tuser;
            in_count_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_res_reg <= eval_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {7'd0, out_res_reg.slice_contiguous,
                            out_res_reg.slice_length, out_res_reg.slice_offset};

endmodule

FILE: rtl/core/rbsm_eval.sv
// rbsm_eval: one request evaluated against the current ring state, giving result and next state
// depends on rbsm_pkg
module rbsm_eval (
    input  logic [15:0]          capacity,
    input  rbsm_pkg::ring_state_t cur_state,
    input  rbsm_pkg::req_t       req_type,
    input  logic [15:0]          byte_count,
    output rbsm_pkg::result_t    result,
    output rbsm_pkg::ring_state_t next_state
);
    import rbsm_pkg::*;

    function automatic logic [POS_W-1:0] advance_pos(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] n,
        input logic [POS_W-1:0] cap
    );
        logic [POS_W:0] s;
        s = {1'b0, pos} + {1'b0, n};
        if (s >= {1'b0, cap})
        begin
            s = s - {1'b0, cap};
        end
        return s[POS_W-1:0];
    endfunction

    logic [POS_W:0]   cap_x;
    logic [POS_W:0]   n_x;
    logic [POS_W:0]   free_x;
    logic [POS_W-1:0] fill_up;
    logic [POS_W-1:0] fill_down;
    logic [POS_W-1:0] wp_adv;
    logic [POS_W-1:0] rp_adv;

    assign cap_x     = {1'b0, capacity};
    assign n_x       = {1'b0, byte_count};
    assign free_x    = cap_x - {1'b0, cur_state.fill_count};
    assign fill_up   = cur_state.fill_count + byte_count;
    assign fill_down = cur_state.fill_count - byte_count;
    assign wp_adv    = advance_pos(cur_state.write_pos, byte_count, capacity);
    assign rp_adv    = advance_pos(cur_state.read_pos, byte_count, capacity);

    always_comb
    begin
        result.status           = ST_OK;
        result.slice_offset     = '0;
        result.slice_length     = '0;
        result.slice_contiguous = 1'b0;
        next_state              = cur_state;
        case (req_type)
            REQ_PEEK:
            begin
                if (cur_state.fill_count == '0)
                begin
                    result.status = ST_REFUSED;
                end
                else
                begin
                    result.slice_offset = cur_state.read_pos;
                    if (cur_state.wrapped_flag)
                    begin
                        result.slice_length = capacity - cur_state.read_pos;
                    end
                    else
                    begin
                        result.slice_length     = cur_state.fill_count;
                        result.slice_contiguous = 1'b1;
                    end
                end
            end
            REQ_RESERVE:
            begin
                if (byte_count == '0)
                begin
                    result.status = ST_BAD_PARAM;
                end
                else if (n_x > free_x)
                begin
                    result.status = ST_REFUSED;
                end
                else
                begin
                    result.slice_offset = cur_state.write_pos;
                    if (({1'b0, cur_state.write_pos} + n_x) > cap_x)
                    begin
                        result.slice_length = capacity - cur_state.write_pos;
                    end
                    else
                    begin
                        result.slice_length     = byte_count;
                        result.slice_contiguous = 1'b1;
                    end
                end
            end
            REQ_COMMIT:
            begin
                if (byte_count == '0)
                begin
                    result.status = ST_BAD_PARAM;
                end
                else if (n_x > free_x)
                begin
                    result.status = ST_REFUSED;
                end
                else
                begin
                    next_state.write_pos    = wp_adv;
                    next_state.fill_count   = fill_up;
                    next_state.wrapped_flag =
                        ({1'b0, cur_state.read_pos} + {1'b0, fill_up}) > cap_x;
                end
            end
            REQ_CONSUME:
            begin
                if (byte_count == '0)
                begin
                    result.status = ST_BAD_PARAM;
                end
                else if (byte_count > cur_state.fill_count)
                begin
                    result.status = ST_REFUSED;
                end
                else
                begin
                    next_state.read_pos     = rp_adv;
                    next_state.fill_count   = fill_down;
                    next_state.wrapped_flag =
                        ({1'b0, rp_adv} + {1'b0, fill_down}) > cap_x;
                end
            end
            default:
            begin
                result.status = ST_REFUSED;
            end
        endcase
    end

endmodule

FILE: rtl/core/rbsm_checker.sv
// rbsm_checker: port-level assertions for ring_buffer_space_manager_top, bound to the top level
// depends on rbsm_pkg
module rbsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import rbsm_pkg::*;

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_BAD_PARAM
                           || m_axis_tuser == ST_REFUSED))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 40'd0)
        else $error("failed request reports a slice");

    a_contig_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |->
            m_axis_tuser == ST_OK && m_axis_tdata[31:16] != 16'd0)
        else $error("contiguous slice with no length");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("padding bits set");

endmodule

bind ring_buffer_space_manager_top rbsm_checker u_rbsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_ring_buffer_space_manager_top.sv
// tb_ring_buffer_space_manager_top: self-checking testbench for the ring buffer space manager
// depends on rbsm_pkg and ring_buffer_space_manager_top; a directed table, then random
// requests under several capacities, results checked against table entries or a ring model
module tb_ring_buffer_space_manager_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbsm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned REQS_PER_PHASE = 190;
    localparam int unsigned NUM_PHASES = 9;
    localparam int unsigned NUM_DIRECTED = 22;
    localparam int unsigned SETTLE_CYCLES = 6;

    localparam result_t REFUSED_RES   = '{ST_REFUSED, 16'd0, 16'd0, 1'b0};
    localparam result_t BAD_PARAM_RES = '{ST_BAD_PARAM, 16'd0, 16'd0, 1'b0};
    localparam result_t PLAIN_OK_RES  = '{ST_OK, 16'd0, 16'd0, 1'b0};

    typedef struct {
        req_t        req;
        logic [15:0] count;
        bit          known;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] byte_count
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [15:0] slice_offset, [31:16] slice_length, [32] slice_contiguous
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int unsigned ring_cap;
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_fill;
    bit          ring_wrapped;

    result_t     pending_results[$];
    stim_row_t   directed_rows[NUM_DIRECTED];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          src_calm;
    bit          sink_calm;

    ring_buffer_space_manager_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned ring_advance(input int unsigned pos, input int unsigned n);
        int unsigned sum;
        sum = pos + n;
        if (sum >= ring_cap)
        begin
            sum = sum - ring_cap;
        end
        return sum;
    endfunction

    function automatic result_t predict_request(input req_t req, input logic [15:0] count);
        result_t     res;
        int unsigned n;
        int unsigned room;
        res = PLAIN_OK_RES;
        n = count;
        room = ring_cap - ring_fill;
        if (req == REQ_PEEK)
        begin
            if (ring_fill == 0)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                res.slice_offset = 16'(ring_tail);
                if (ring_wrapped)
                begin
                    res.slice_length = 16'(ring_cap - ring_tail);
                end
                else
                begin
                    res.slice_length = 16'(ring_fill);
                    res.slice_contiguous = 1'b1;
                end
            end
        end
        else if (n == 0)
        begin
            res.status = ST_BAD_PARAM;
        end
        else if (req == REQ_RESERVE)
        begin
            if (n > room)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                res.slice_offset = 16'(ring_head);
                if (ring_head + n > ring_cap)
                begin
                    res.slice_length = 16'(ring_cap - ring_head);
                end
                else
                begin
                    res.slice_length = count;
                    res.slice_contiguous = 1'b1;
                end
            end
        end
        else if (req == REQ_COMMIT)
        begin
            if (n > room)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                ring_head = ring_advance(ring_head, n);
                ring_fill = ring_fill + n;
                ring_wrapped = (ring_tail + ring_fill > ring_cap);
            end
        end
        else
        begin
            if (n > ring_fill)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                ring_tail = ring_advance(ring_tail, n);
                ring_fill = ring_fill - n;
                ring_wrapped = (ring_tail + ring_fill > ring_cap);
            end
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones, none in a calm stretch
    function automatic int unsigned gap_len(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // sizes follow the free space or fill level so that full and wrapped states are reached
    function automatic void pick_request(output req_t req, output logic [15:0] count);
        int unsigned roll;
        int unsigned limit;
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            req = REQ_RESERVE;
        end
        else if (roll < 50)
        begin
            req = REQ_COMMIT;
        end
        else if (roll < 70)
        begin
            req = REQ_PEEK;
        end
        else
        begin
            req = REQ_CONSUME;
        end
        limit = (req == REQ_CONSUME) ? ring_fill : ring_cap - ring_fill;
        roll = $urandom_range(0, 99);
        if (req == REQ_PEEK || (roll >= 6 && roll < 14))
        begin
            count = 16'($urandom);
        end
        else if (roll < 6)
        begin
            count = 16'd0;
        end
        else if (limit == 0)
        begin
            count = 16'($urandom_range(1, 3));
        end
        else if (roll < 30)
        begin
            count = 16'(limit);
        end
        else if (roll < 36)
        begin
            count = 16'(limit + 1);
        end
        else
        begin
            count = 16'($urandom_range(1, limit));
        end
    endfunction

    task automatic send_request(input req_t req, input logic [15:0] count, input bit known,
                                input result_t want);
        int unsigned idle;
        result_t     predicted;
        idle = gap_len(src_calm);
        if (idle != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= count;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predicted = predict_request(req, count);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value != 16'd0)
        begin
            ring_cap = value;
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
            ring_wrapped = 1'b0;
        end
    endtask

    initial
    begin
        req_t        req;
        logic [15:0] count;
        logic [15:0] caps[NUM_PHASES];
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 16'd0;
        s_axis_tuser <= REQ_RESERVE;
        cfg_we <= 1'b0;
        cfg_wdata <= 16'd0;
        error_count = 0;
        src_calm = 1'b0;
        ring_cap = CAP_RESET;
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
        ring_wrapped = 1'b0;
        directed_rows = '{
            '{REQ_PEEK,    16'd0,     1'b1, REFUSED_RES},
            '{REQ_RESERVE, 16'd0,     1'b1, BAD_PARAM_RES},
            '{REQ_COMMIT,  16'd0,     1'b1, BAD_PARAM_RES},
            '{REQ_CONSUME, 16'd0,     1'b1, BAD_PARAM_RES},
            '{REQ_RESERVE, 16'hFFFF,  1'b1, REFUSED_RES},
            '{REQ_COMMIT,  16'hFFFF,  1'b1, REFUSED_RES},
            '{REQ_CONSUME, 16'd1,     1'b1, REFUSED_RES},
            '{REQ_PEEK,    16'hFFFF,  1'b1, REFUSED_RES},
            '{REQ_RESERVE, 16'd4096,  1'b1, '{ST_OK, 16'd0, 16'd4096, 1'b1}},
            '{REQ_COMMIT,  16'd4096,  1'b1, PLAIN_OK_RES},
            '{REQ_PEEK,    16'd0,     1'b0, PLAIN_OK_RES},
            '{REQ_RESERVE, 16'd1,     1'b1, REFUSED_RES},
            '{REQ_COMMIT,  16'd1,     1'b1, REFUSED_RES},
            '{REQ_CONSUME, 16'd4000,  1'b0, PLAIN_OK_RES},
            '{REQ_COMMIT,  16'd4000,  1'b0, PLAIN_OK_RES},
            '{REQ_PEEK,    16'd0,     1'b0, PLAIN_OK_RES},
            '{REQ_CONSUME, 16'd100,   1'b0, PLAIN_OK_RES},
            '{REQ_RESERVE, 16'd100,   1'b0, PLAIN_OK_RES},
            '{REQ_COMMIT,  16'd50,    1'b0, PLAIN_OK_RES},
            '{REQ_PEEK,    16'd0,     1'b0, PLAIN_OK_RES},
            '{REQ_CONSUME, 16'd4046,  1'b0, PLAIN_OK_RES},
            '{REQ_PEEK,    16'd0,     1'b1, REFUSED_RES}
        };
        // a zero write follows the largest capacity and must leave its state alone
        caps = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd100, 16'd4096,
                 16'($urandom_range(1, 65535)), 16'd37, 16'($urandom_range(1, 65535))};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].count,
                         directed_rows[i].known, directed_rows[i].want);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(caps[p]);
            for (int i = 0; i < REQS_PER_PHASE; i++)
            begin
                if (i % 64 == 0)
                begin
                    src_calm = ($urandom_range(0, 3) == 0);
                end
                pick_request(req, count);
                send_request(req, count, 1'b0, PLAIN_OK_RES);
            end
            drain_results();
        end

        if (error_count == 0)
        begin
            $display("** ring_buffer_space_manager_top: PASSED **");
        end
        else
        begin
            $display("** ring_buffer_space_manager_top: FAILED **");
        end
        $finish;
    end

    initial
    begin
        int unsigned stall;
        int unsigned bursts;
        m_axis_tready <= 1'b0;
        sink_calm = 1'b0;
        bursts = 0;
        forever
        begin
            if (bursts % 20 == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            bursts++;
            stall = gap_len(sink_calm);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d data %h",
                       m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[15:0] !== want.slice_offset)
                begin
                    $error("slice_offset: expected %0d, got %0d",
                           want.slice_offset, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[31:16] !== want.slice_length)
                begin
                    $error("slice_length: expected %0d, got %0d",
                           want.slice_length, m_axis_tdata[31:16]);
                    error_count++;
                end
                if (m_axis_tdata[32] !== want.slice_contiguous)
                begin
                    $error("slice_contiguous: expected %0d, got %0d",
                           want.slice_contiguous, m_axis_tdata[32]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("** ring_buffer_space_manager_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
